@@ design/lattice_neighbor_enumerator_assert.svh @@
// Assertion macros used by the lattice neighbor enumerator checker.
`ifndef LATTICE_NEIGHBOR_ENUMERATOR_ASSERT_SVH
`define LATTICE_NEIGHBOR_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LNE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lne same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LNE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lne next-cycle check failed");

`endif

@@ design/lne_pkg.sv @@
// Types and constants of the lattice neighbor enumerator.
package lne_pkg;

    localparam int SITE_W     = 24;
    localparam int NUM_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int HOP_W      = 2;
    localparam int SHELL_N    = 32;
    localparam int FACE_N     = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SIZE    = 2'd0,
        REG_Y_SIZE    = 2'd1,
        REG_Z_SIZE    = 2'd2,
        REG_HOP_RANGE = 2'd3
    } t_cfg_reg;

    localparam logic [HOP_W-1:0] HOP_EXT = 2'd2;

    localparam int X_RST   = 16;
    localparam int Y_RST   = 16;
    localparam int Z_RST   = 1;
    localparam logic [HOP_W-1:0] HOP_RST = 2'd1;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
        logic signed [2:0] dz;
    } t_ofs;

    // Extended shell: west side, east side, below, above, south/north axial.
    localparam t_ofs SHELL_TAB [SHELL_N] = '{
        '{-3'sd1,  3'sd0,  3'sd0}, '{-3'sd1, -3'sd1,  3'sd0},
        '{-3'sd1, -3'sd1, -3'sd1}, '{-3'sd1, -3'sd1,  3'sd1},
        '{-3'sd1,  3'sd1,  3'sd0}, '{-3'sd1,  3'sd1, -3'sd1},
        '{-3'sd1,  3'sd1,  3'sd1}, '{-3'sd1,  3'sd0, -3'sd1},
        '{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2,  3'sd0,  3'sd0},
        '{ 3'sd1,  3'sd0,  3'sd0}, '{ 3'sd1, -3'sd1,  3'sd0},
        '{ 3'sd1, -3'sd1, -3'sd1}, '{ 3'sd1, -3'sd1,  3'sd1},
        '{ 3'sd1,  3'sd1,  3'sd0}, '{ 3'sd1,  3'sd1, -3'sd1},
        '{ 3'sd1,  3'sd1,  3'sd1}, '{ 3'sd1,  3'sd0, -3'sd1},
        '{ 3'sd1,  3'sd0,  3'sd1}, '{ 3'sd2,  3'sd0,  3'sd0},
        '{ 3'sd0,  3'sd0, -3'sd1}, '{ 3'sd0, -3'sd1, -3'sd1},
        '{ 3'sd0,  3'sd1, -3'sd1}, '{ 3'sd0,  3'sd0, -3'sd2},
        '{ 3'sd0,  3'sd0,  3'sd1}, '{ 3'sd0, -3'sd1,  3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd1}, '{ 3'sd0,  3'sd0,  3'sd2},
        '{ 3'sd0, -3'sd1,  3'sd0}, '{ 3'sd0, -3'sd2,  3'sd0},
        '{ 3'sd0,  3'sd1,  3'sd0}, '{ 3'sd0,  3'sd2,  3'sd0}
    };

    // Face neighbors; the last two entries pad the table to a power of two.
    localparam t_ofs FACE_TAB [8] = '{
        '{-3'sd1,  3'sd0,  3'sd0}, '{ 3'sd1,  3'sd0,  3'sd0},
        '{ 3'sd0, -3'sd1,  3'sd0}, '{ 3'sd0,  3'sd1,  3'sd0},
        '{ 3'sd0,  3'sd0, -3'sd1}, '{ 3'sd0,  3'sd0,  3'sd1},
        '{ 3'sd0,  3'sd0,  3'sd0}, '{ 3'sd0,  3'sd0,  3'sd0}
    };

endpackage

@@ design/lne_site_if.sv @@
// Input channel: one site index per item.
interface lne_site_if;
    import lne_pkg::*;
    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] site_index;
    modport source (output valid, output site_index, input ready);
    modport sink   (input valid, input site_index, output ready);
endinterface

@@ design/lne_nbr_if.sv @@
// Output channel: one neighbor per item.
interface lne_nbr_if;
    import lne_pkg::*;
    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] neighbor_site;
    logic [NUM_W-1:0]  neighbor_number;
    logic              last;
    logic              bad_site;
    modport source (output valid, output neighbor_site, output neighbor_number,
                    output last, output bad_site, input ready);
    modport sink   (input valid, input neighbor_site, input neighbor_number,
                    input last, input bad_site, output ready);
endinterface

@@ design/lne_cfg_if.sv @@
// Configuration write channel.
interface lne_cfg_if;
    import lne_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/lne_div.sv @@
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
module lne_div #(
    parameter int DW   = 24,
    parameter int VW   = 9,
    parameter int SW   = 1,
    parameter int STEP = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic [SW-1:0] o_side
);
    localparam int NST = (DW + STEP - 1) / STEP;
    localparam int PW  = NST * STEP;

    logic          r_v    [NST];
    logic [PW-1:0] r_num  [NST];
    logic [VW-1:0] r_rem  [NST];
    logic [VW-1:0] r_den  [NST];
    logic [SW-1:0] r_side [NST];

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic          v_in;
        logic [PW-1:0] num_in;
        logic [VW-1:0] rem_in;
        logic [VW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [PW-1:0] n_num;
        logic [VW-1:0] n_rem;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign num_in  = PW'(i_num);
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_body
            assign v_in    = r_v[k-1];
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            logic [VW:0]   rem;
            logic [PW-1:0] num;
            rem = {1'b0, rem_in};
            num = num_in;
            for (int j = 0; j < STEP; j++) begin
                rem = {rem[VW-1:0], num[PW-1]};
                num = {num[PW-2:0], 1'b0};
                if (rem >= {1'b0, den_in}) begin
                    rem    = rem - {1'b0, den_in};
                    num[0] = 1'b1;
                end
            end
            n_rem = rem[VW-1:0];
            n_num = num;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quo   = r_num[NST-1][DW-1:0];
    assign o_rem   = r_rem[NST-1];
    assign o_side  = r_side[NST-1];
endmodule

@@ design/lattice_neighbor_enumerator.sv @@
// Lattice neighbor enumerator: site index to in-bounds neighbor indices.
// Pipeline: two 6-stage dividers, bounds check, mask build, emitter load, three output
//   stages.
// Throughput: one result per cycle unless the output stalls; an item holds the emitter until
//   its last result is issued (0..32 results per item), and the next item waits for it.
// Reset: synchronous, active low; sizes return to 16 x 16 x 1, range 1, pipeline empty.
module lattice_neighbor_enumerator #(
    parameter int MAX_SIDE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lne_site_if.sink   i_site,
    lne_nbr_if.source  o_nbr,
    lne_cfg_if.sink    i_cfg
);
    import lne_pkg::*;

    localparam int SW    = $clog2(MAX_SIDE + 1);   // size register width
    localparam int CW    = $clog2(MAX_SIDE);       // coordinate width
    localparam int AW    = 2 * SW;
    localparam int VOLW  = 3 * SW;
    localparam int CMPW  = VOLW + SITE_W;
    localparam int ZYW   = CW + SW + 1;
    localparam int PRW   = SW + ZYW + 1;
    localparam int CMAX  = CW + 3;
    localparam int XR    = (X_RST > MAX_SIDE) ? MAX_SIDE : X_RST;
    localparam int YR    = (Y_RST > MAX_SIDE) ? MAX_SIDE : Y_RST;
    localparam int ZR    = (Z_RST > MAX_SIDE) ? MAX_SIDE : Z_RST;

    // ---------------- configuration ----------------
    logic [SW-1:0]    r_x_size, r_y_size, r_z_size;
    logic [HOP_W-1:0] r_hop;
    logic [AW-1:0]    r_area;
    logic [VOLW-1:0]  r_vol;
    logic [SW-1:0]    n_side;
    logic             hop_ext;

    assign i_cfg.ready = 1'b1;
    assign hop_ext     = (r_hop == HOP_EXT);

    // Sizes saturate into 1..MAX_SIDE when written.
    always_comb begin
        if (i_cfg.data == '0) begin
            n_side = SW'(1);
        end else if (int'(i_cfg.data) > MAX_SIDE) begin
            n_side = SW'(MAX_SIDE);
        end else begin
            n_side = SW'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= SW'(XR);
            r_y_size <= SW'(YR);
            r_z_size <= SW'(ZR);
            r_hop    <= HOP_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_X_SIZE:    r_x_size <= n_side;
                REG_Y_SIZE:    r_y_size <= n_side;
                REG_Z_SIZE:    r_z_size <= n_side;
                REG_HOP_RANGE: r_hop    <= i_cfg.data[HOP_W-1:0];
                default:       r_hop    <= r_hop;
            endcase
        end
    end

    // Volume is registered from the area, which is registered from the sizes.
    always_ff @(posedge i_clk) begin
        r_area <= r_x_size * r_y_size;
        r_vol  <= VOLW'(r_area) * VOLW'(r_z_size);
    end

    // ---------------- front pipeline: coordinates ----------------
    logic en_f;   // front stages advance
    logic en_b;   // back stages advance

    logic              d1_v;
    logic [SITE_W-1:0] d1_q;
    logic [SW-1:0]     d1_r;
    logic [SITE_W-1:0] d1_site;

    assign i_site.ready = en_f;

    // s / X gives x as remainder
    lne_div #(.DW(SITE_W), .VW(SW), .SW(SITE_W), .STEP(4)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_f),
        .i_valid (i_site.valid),
        .i_num   (i_site.site_index),
        .i_den   (r_x_size),
        .i_side  (i_site.site_index),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_rem   (d1_r),
        .o_side  (d1_site)
    );

    logic                 d2_v;
    logic [SITE_W-1:0]    d2_q;
    logic [SW-1:0]        d2_r;
    logic [SITE_W+CW-1:0] d2_side;

    // (s / X) / Y gives z, remainder y
    lne_div #(.DW(SITE_W), .VW(SW), .SW(SITE_W + CW), .STEP(4)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_f),
        .i_valid (d1_v),
        .i_num   (d1_q),
        .i_den   (r_y_size),
        .i_side  ({d1_site, d1_r[CW-1:0]}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_rem   (d2_r),
        .o_side  (d2_side)
    );

    // Stage C: bounds check against the volume.
    logic          r_c_v, r_c_bad;
    logic [CW-1:0] r_c_x, r_c_y, r_c_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_f) begin
            r_c_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_c_bad <= CMPW'(d2_side[SITE_W+CW-1:CW]) >= CMPW'(r_vol);
            r_c_x   <= d2_side[CW-1:0];
            r_c_y   <= d2_r[CW-1:0];
            r_c_z   <= d2_q[CW-1:0];
        end
    end

    // Stage M: in-bounds mask over the candidate list, in emission order.
    function automatic logic inb(logic [CW-1:0] c, logic signed [2:0] o, logic [SW-1:0] n);
        logic signed [CMAX-1:0] p;
        logic signed [CMAX-1:0] lim;
        p   = $signed(CMAX'(c)) + CMAX'(o);
        lim = $signed(CMAX'(n));
        return (p >= 0) && (p < lim);
    endfunction

    logic [SHELL_N-1:0] n_mask;

    always_comb begin
        n_mask = '0;
        if (hop_ext) begin
            for (int k = 0; k < SHELL_N; k++) begin
                n_mask[k] = inb(r_c_x, SHELL_TAB[k].dx, r_x_size)
                          & inb(r_c_y, SHELL_TAB[k].dy, r_y_size)
                          & inb(r_c_z, SHELL_TAB[k].dz, r_z_size);
            end
        end else begin
            for (int k = 0; k < FACE_N; k++) begin
                n_mask[k] = inb(r_c_x, FACE_TAB[k].dx, r_x_size)
                          & inb(r_c_y, FACE_TAB[k].dy, r_y_size)
                          & inb(r_c_z, FACE_TAB[k].dz, r_z_size);
            end
        end
    end

    logic               r_m_v, r_m_bad;
    logic [SHELL_N-1:0] r_m_mask;
    logic [CW-1:0]      r_m_x, r_m_y, r_m_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en_f) begin
            r_m_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_m_bad  <= r_c_bad;
            r_m_mask <= r_c_bad ? '0 : n_mask;
            r_m_x    <= r_c_x;
            r_m_y    <= r_c_y;
            r_m_z    <= r_c_z;
        end
    end

    // ---------------- emitter: one neighbor per cycle while the output is not stalled ----------------
    logic               r_busy, r_bad;
    logic [SHELL_N-1:0] r_mask;
    logic [CW-1:0]      r_x, r_y, r_z;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   sel;
    logic [SHELL_N-1:0] rest;
    logic               pick_last;
    logic               adv_e;
    logic               load_ok;
    t_ofs               ofs;

    // lowest pending candidate
    always_comb begin
        sel = '0;
        for (int k = SHELL_N - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = NUM_W'(k);
            end
        end
        rest      = r_mask & ~(SHELL_N'(1) << sel);
        pick_last = r_bad || (rest == '0);
        ofs       = hop_ext ? SHELL_TAB[sel] : FACE_TAB[sel[2:0]];
    end

    assign adv_e   = r_busy && en_b;
    assign load_ok = !r_busy || (adv_e && pick_last);
    assign en_f    = !r_m_v || load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (r_m_v && load_ok) begin
            // an item without neighbors is dropped here
            r_busy <= r_m_bad || (r_m_mask != '0);
        end else if (adv_e && pick_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_v && load_ok) begin
            r_mask <= r_m_mask;
            r_bad  <= r_m_bad;
            r_x    <= r_m_x;
            r_y    <= r_m_y;
            r_z    <= r_m_z;
            r_num  <= '0;
        end else if (adv_e) begin
            r_mask <= rest;
            r_num  <= r_num + NUM_W'(1);
        end
    end

    // ---------------- back pipeline: linear index ----------------
    logic             r_e1_v, r_e1_last, r_e1_bad;
    logic [CW-1:0]    r_e1_x, r_e1_y, r_e1_z;
    logic [NUM_W-1:0] r_e1_num;

    logic             r_e2_v, r_e2_last, r_e2_bad;
    logic [ZYW-1:0]   r_e2_zy;
    logic [CW-1:0]    r_e2_x;
    logic [NUM_W-1:0] r_e2_num;

    logic              r_o_v, r_o_last, r_o_bad;
    logic [SITE_W-1:0] r_o_site;
    logic [NUM_W-1:0]  r_o_num;
    logic [PRW-1:0]    n_site;

    assign en_b = !r_o_v || o_nbr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (en_b) begin
            r_e1_v <= r_busy;
            r_e2_v <= r_e1_v;
            r_o_v  <= r_e2_v;
        end
    end

    assign n_site = PRW'(r_x_size) * PRW'(r_e2_zy) + PRW'(r_e2_x);

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_e1_x    <= CW'($signed({2'b00, r_x}) + (CW + 2)'(ofs.dx));
            r_e1_y    <= CW'($signed({2'b00, r_y}) + (CW + 2)'(ofs.dy));
            r_e1_z    <= CW'($signed({2'b00, r_z}) + (CW + 2)'(ofs.dz));
            r_e1_num  <= r_num;
            r_e1_last <= pick_last;
            r_e1_bad  <= r_bad;

            r_e2_zy   <= ZYW'(r_e1_z) * ZYW'(r_y_size) + ZYW'(r_e1_y);
            r_e2_x    <= r_e1_x;
            r_e2_num  <= r_e1_num;
            r_e2_last <= r_e1_last;
            r_e2_bad  <= r_e1_bad;

            r_o_site  <= r_e2_bad ? '0 : n_site[SITE_W-1:0];
            r_o_num   <= r_e2_bad ? '0 : r_e2_num;
            r_o_last  <= r_e2_last;
            r_o_bad   <= r_e2_bad;
        end
    end

    assign o_nbr.valid           = r_o_v;
    assign o_nbr.neighbor_site   = r_o_site;
    assign o_nbr.neighbor_number = r_o_num;
    assign o_nbr.last            = r_o_last;
    assign o_nbr.bad_site        = r_o_bad;
endmodule

@@ design/lne_checker.sv @@
// Port-level checks of the lattice neighbor enumerator, bound to the top level.
`include "lattice_neighbor_enumerator_assert.svh"

module lne_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [lne_pkg::SITE_W-1:0] i_out_site,
    input logic [lne_pkg::NUM_W-1:0]  i_out_number,
    input logic                      i_out_last,
    input logic                      i_out_bad,
    input logic                      i_cfg_valid,
    input logic                      i_cfg_ready
);
    import lne_pkg::*;

    localparam logic [NUM_W-1:0] NUM_TOP = '1;

    logic                    bad_shape;
    logic                    top_v;
    logic                    out_stall;
    logic [SITE_W+NUM_W+1:0] out_word;

    assign bad_shape = i_out_last && (i_out_site == '0) && (i_out_number == '0);
    assign top_v     = i_out_valid && !i_out_bad && (i_out_number == NUM_TOP);
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_out_site, i_out_number, i_out_last, i_out_bad};

    // a bad site is a single marked result
    `LNE_ASSERT_IMP(a_bad_single, i_clk, i_rst_n, i_out_valid && i_out_bad, bad_shape)
    // the 32nd neighbor always closes the list
    `LNE_ASSERT_IMP(a_top_last, i_clk, i_rst_n, top_v, i_out_last)
    // configuration is never back-pressured
    `LNE_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready)
    // a stalled result holds
    `LNE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))
endmodule

bind lattice_neighbor_enumerator lne_checker u_lne_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_nbr.valid),
    .i_out_ready  (o_nbr.ready),
    .i_out_site   (o_nbr.neighbor_site),
    .i_out_number (o_nbr.neighbor_number),
    .i_out_last   (o_nbr.last),
    .i_out_bad    (o_nbr.bad_site),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready)
);
